// ----- rtl/core/cde_pkg.sv -----
// ----------------------------------------------------------------------------
// Calendar date engine package
// Shared item types, operation and status codes, the controller command and
// status structs, and the month length table.
// ----------------------------------------------------------------------------
package cde_pkg;

  // Operation codes carried in the func field. Code 3 acts as validate.
  localparam logic [1:0] FN_VALIDATE = 2'd0;
  localparam logic [1:0] FN_ADD      = 2'd1;
  localparam logic [1:0] FN_DIFF     = 2'd2;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EARLIER  = 2'd3
  } cde_status_t;

  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [13:0] YEAR_MAX   = 14'd9999;
  localparam logic [13:0] YEAR_CYCLE = 14'd400;
  localparam logic [21:0] DAYS_400Y  = 22'd146097;
  localparam logic [6:0]  CENTURY_LAST = 7'd99;

  // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y.
  localparam int RECIP_100   = 10486;
  localparam int RECIP_SHIFT = 20;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  date_day;
    logic [3:0]  date_month;
    logic [13:0] date_year;
    logic [4:0]  other_day;
    logic [3:0]  other_month;
    logic [13:0] other_year;
    logic [15:0] add_count;
  } cde_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [13:0] res_year;
    logic [21:0] day_count;
  } cde_rsp_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_YQ_OTHER,
    OP_YR_OTHER,
    OP_SAVE_OK2,
    OP_YQ_DATE,
    OP_YR_DATE,
    OP_INIT_CNT,
    OP_ADD_STEP,
    OP_DIFF_STEP,
    OP_FINISH
  } cde_op_t;

  typedef struct packed {
    cde_op_t     op;
    cde_status_t status;
  } cde_cmd_t;

  typedef struct packed {
    logic ok;        // date in the cursor registers is valid
    logic ok2;       // second date was valid
    logic earlier;   // second date lies before the cursor date
    logic is_add;
    logic is_diff;
    logic add_ovf;   // add walk went past the last year
    logic add_done;  // this add step lands on the result date
    logic diff_done; // this difference step is the last one
    logic rsp_busy;  // result register full and stalled
  } cde_stat_t;

  function automatic logic [4:0] cde_month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      MONTH_FEB:                                   len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- rtl/core/cde_datapath.sv -----
// ----------------------------------------------------------------------------
// Calendar date engine datapath
// Item register, date cursor with year residue counters, day counter and the
// result register.
// ----------------------------------------------------------------------------
module cde_datapath (
  input  logic           clk,
  input  logic           rst,
  input  cde_pkg::cde_cmd_t cmd,
  output cde_pkg::cde_stat_t st,
  input  cde_pkg::cde_req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cde_pkg::cde_rsp_t  rsp
);
  import cde_pkg::*;

  cde_req_t    item;
  logic [4:0]  d;
  logic [3:0]  m;
  logic [13:0] y;
  logic [6:0]  r100;   // y mod 100
  logic [1:0]  hc;     // (y / 100) mod 4
  logic [7:0]  q;      // y / 100 from the reciprocal multiply
  logic [21:0] cnt;
  logic        ok2;

  logic [13:0] ysel;
  logic [27:0] prod;
  logic [13:0] q_mul100;
  logic [6:0]  r100_load;
  logic [13:0] y_inc;
  logic [6:0]  r100_inc;
  logic [1:0]  hc_inc;
  logic        leap;
  logic [4:0]  mlen;
  logic [8:0]  ylen;
  logic [4:0]  room;
  logic [5:0]  room1;
  logic        at_jan1;
  logic        ok;
  logic        add_ovf;
  logic        add_jump;
  logic        add_fits;
  logic        same_month;
  logic [13:0] ydiff;
  logic        jump400;
  logic        jump1;
  logic [4:0]  day_gap;
  logic        fin_ok;

  assign ysel = (cmd.op == OP_YQ_OTHER || cmd.op == OP_YR_OTHER) ?
                item.other_year : item.date_year;
  assign prod      = 28'(ysel) * 28'(RECIP_100);
  assign q_mul100  = 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
  assign r100_load = 7'(ysel - q_mul100);

  assign y_inc    = y + 14'd1;
  assign r100_inc = (r100 == CENTURY_LAST) ? 7'd0 : r100 + 7'd1;
  assign hc_inc   = (r100 == CENTURY_LAST) ? hc + 2'd1 : hc;

  assign leap    = (y[1:0] == 2'd0) && ((r100 != 7'd0) || (hc == 2'd0));
  assign mlen    = cde_month_len(m, leap);
  assign ylen    = leap ? 9'd366 : 9'd365;
  assign room    = mlen - d;
  assign room1   = {1'b0, room} + 6'd1;
  assign at_jan1 = (d == 5'd1) && (m == MONTH_JAN);

  assign ok = (y != 14'd0) && (y <= YEAR_MAX) && (d != 5'd0) && (d <= mlen);

  assign add_ovf  = y > YEAR_MAX;
  assign add_jump = at_jan1 && (cnt >= 22'(ylen));
  assign add_fits = cnt <= 22'(room);

  assign same_month = (y == item.other_year) && (m == item.other_month);
  assign ydiff      = item.other_year - y;
  assign jump400    = at_jan1 && (ydiff >= YEAR_CYCLE);
  assign jump1      = at_jan1 && (y < item.other_year);
  assign day_gap    = item.other_day - d;

  assign st.ok        = ok;
  assign st.ok2       = ok2;
  assign st.earlier   = {item.other_year, item.other_month, item.other_day} < {y, m, d};
  assign st.is_add    = item.func == FN_ADD;
  assign st.is_diff   = item.func == FN_DIFF;
  assign st.add_ovf   = add_ovf;
  assign st.add_done  = !add_ovf && !add_jump && add_fits;
  assign st.diff_done = same_month;
  assign st.rsp_busy  = rsp_valid && rsp_stall;

  assign fin_ok = cmd.status == ST_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        item <= req;
      end
      OP_YQ_OTHER, OP_YQ_DATE: begin
        q <= prod[RECIP_SHIFT +: 8];
      end
      OP_YR_OTHER: begin
        d    <= item.other_day;
        m    <= item.other_month;
        y    <= ysel;
        r100 <= r100_load;
        hc   <= q[1:0];
      end
      OP_YR_DATE: begin
        d    <= item.date_day;
        m    <= item.date_month;
        y    <= ysel;
        r100 <= r100_load;
        hc   <= q[1:0];
      end
      OP_SAVE_OK2: begin
        ok2 <= ok;
      end
      OP_INIT_CNT: begin
        cnt <= (item.func == FN_ADD) ? 22'(item.add_count) : 22'd0;
      end
      OP_ADD_STEP: begin
        if (!add_ovf) begin
          priority if (add_jump) begin
            cnt  <= cnt - 22'(ylen);
            y    <= y_inc;
            r100 <= r100_inc;
            hc   <= hc_inc;
          end else if (add_fits) begin
            d <= d + cnt[4:0];
          end else begin
            cnt <= cnt - 22'(room1);
            d   <= 5'd1;
            if (m == MONTH_DEC) begin
              m    <= MONTH_JAN;
              y    <= y_inc;
              r100 <= r100_inc;
              hc   <= hc_inc;
            end else begin
              m <= m + 4'd1;
            end
          end
        end
      end
      OP_DIFF_STEP: begin
        priority if (same_month) begin
          cnt <= cnt + 22'(day_gap);
        end else if (jump400) begin
          cnt <= cnt + DAYS_400Y;
          y   <= y + YEAR_CYCLE;
        end else if (jump1) begin
          cnt  <= cnt + 22'(ylen);
          y    <= y_inc;
          r100 <= r100_inc;
          hc   <= hc_inc;
        end else begin
          cnt <= cnt + 22'(room1);
          d   <= 5'd1;
          if (m == MONTH_DEC) begin
            m    <= MONTH_JAN;
            y    <= y_inc;
            r100 <= r100_inc;
            hc   <= hc_inc;
          end else begin
            m <= m + 4'd1;
          end
        end
      end
      OP_FINISH: begin
        rsp.status <= cmd.status;
        if (fin_ok && item.func == FN_ADD) begin
          rsp.res_day   <= d;
          rsp.res_month <= m;
          rsp.res_year  <= y;
        end else begin
          rsp.res_day   <= item.date_day;
          rsp.res_month <= item.date_month;
          rsp.res_year  <= item.date_year;
        end
        rsp.day_count <= (fin_ok && item.func == FN_DIFF) ? cnt : 22'd0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/cde_ctrl.sv -----
// ----------------------------------------------------------------------------
// Calendar date engine controller
// Sequences the year residue loads, the validity checks and the date walk,
// and hands the finished item to the result register.
// ----------------------------------------------------------------------------
module cde_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output cde_pkg::cde_cmd_t  cmd,
  input  cde_pkg::cde_stat_t st
);
  import cde_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q2,
    S_R2,
    S_CHK2,
    S_Q1,
    S_R1,
    S_CHK1,
    S_ADD,
    S_DIFF,
    S_FIN
  } state_t;

  state_t      state;
  cde_status_t fin_status;

  assign req_stall  = state != S_IDLE;
  assign cmd.status = fin_status;

  always_comb begin
    unique case (state)
      S_IDLE:  cmd.op = req_valid ? OP_LOAD : OP_IDLE;
      S_Q2:    cmd.op = OP_YQ_OTHER;
      S_R2:    cmd.op = OP_YR_OTHER;
      S_CHK2:  cmd.op = OP_SAVE_OK2;
      S_Q1:    cmd.op = OP_YQ_DATE;
      S_R1:    cmd.op = OP_YR_DATE;
      S_CHK1:  cmd.op = OP_INIT_CNT;
      S_ADD:   cmd.op = OP_ADD_STEP;
      S_DIFF:  cmd.op = OP_DIFF_STEP;
      S_FIN:   cmd.op = st.rsp_busy ? OP_IDLE : OP_FINISH;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_Q2;
          end
        end
        S_Q2:   state <= S_R2;
        S_R2:   state <= S_CHK2;
        S_CHK2: state <= S_Q1;
        S_Q1:   state <= S_R1;
        S_R1:   state <= S_CHK1;
        S_CHK1: begin
          priority if (st.is_add) begin
            if (st.ok) begin
              state <= S_ADD;
            end else begin
              fin_status <= ST_INVALID;
              state      <= S_FIN;
            end
          end else if (st.is_diff) begin
            priority if (!st.ok || !st.ok2) begin
              fin_status <= ST_INVALID;
              state      <= S_FIN;
            end else if (st.earlier) begin
              fin_status <= ST_EARLIER;
              state      <= S_FIN;
            end else begin
              state <= S_DIFF;
            end
          end else begin
            fin_status <= st.ok ? ST_OK : ST_INVALID;
            state      <= S_FIN;
          end
        end
        S_ADD: begin
          if (st.add_ovf) begin
            fin_status <= ST_OVERFLOW;
            state      <= S_FIN;
          end else if (st.add_done) begin
            fin_status <= ST_OK;
            state      <= S_FIN;
          end
        end
        S_DIFF: begin
          if (st.diff_done) begin
            fin_status <= ST_OK;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!st.rsp_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |-> !st.rsp_busy)
    else $error("result written while the result register was stalled");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid) |=> (state == S_Q2))
    else $error("accepted item did not start the year load");

  a_fin_leave: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !st.rsp_busy) |=> (state == S_IDLE))
    else $error("controller stuck after handing off the result");

  a_ovf_add: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && fin_status == ST_OVERFLOW) |-> st.is_add)
    else $error("year overflow reported for an operation other than add");
`endif

endmodule

// ----- rtl/core/calendar_date_engine.sv -----
// ----------------------------------------------------------------------------
// Calendar date engine
// Gregorian date unit: validates a date, adds a day count to a date, or
// counts the days between two dates.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload          | contents
//  --------+--------------------+------------------+---------------------------
//  req     | req_valid/req_stall| cde_req_t  (64b) | func, two dates, add_count
//  rsp     | rsp_valid/rsp_stall| cde_rsp_t  (47b) | status, date, day_count
//
// One item is in work at a time. Every item first loads and checks the two
// years, the second date's before the first's (one reciprocal multiply for
// y / 100 per date), then hands the result to the output register.
// Validate goes straight to the hand-off. Add walks month by month and a whole
// year per cycle from January 1st; difference also jumps 400 years per cycle.
// Reset is synchronous and clears the controller and the result valid flag.
// The result register frees the input side: a new item is taken while the
// previous result is still stalled, and only the hand-off waits for it.
//
module calendar_date_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  cde_pkg::cde_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output cde_pkg::cde_rsp_t rsp
);
  import cde_pkg::*;

  // Commands flow from the controller to the datapath; status flows back.
  cde_cmd_t  cmd;
  cde_stat_t st;

  // The controller owns the sequence: load, check, walk, finish.
  cde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .st        (st)
  );

  // The datapath holds the item, the date cursor and the result register.
  cde_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
